// ===== rtl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the bilinear texture sampler: transaction
// structs, register indexes, operation and mode codes, state encoding.
// ----------------------------------------------------------------------------
package bts_pkg;

   // Texture store geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Register and field widths
   localparam int SIZE_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int COORD_W    = 17;
   localparam int FRAC_W     = 16;

   localparam logic [COORD_W-1:0] COORD_ONE = 17'h10000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_FILTER_MODE  = 2'd2,
      CSR_CHANNEL_MODE = 2'd3
   } csr_index_type;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic FILTER_NEAREST  = 1'b0;
   localparam logic FILTER_BILINEAR = 1'b1;

   localparam logic [1:0] CHAN_GRAY = 2'd0;
   localparam logic [1:0] CHAN_RGB  = 2'd1;
   localparam logic [1:0] CHAN_RGBA = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ADDR,
      ST_FETCH,
      ST_WAIT,
      ST_VERT,
      ST_HORZ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               op;
      logic [15:0]        texel_index;
      logic [7:0]         in_red;
      logic [7:0]         in_green;
      logic [7:0]         in_blue;
      logic [7:0]         in_alpha;
      logic [COORD_W-1:0] coord_u;
      logic [COORD_W-1:0] coord_v;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       edge_fallback;
   } rsp_type;

endpackage

// ===== rtl/bilinear_texture_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// RGBA8 texel store with nearest and bilinear sampling at 1.16 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per item. A write item (op = write) stores one
//            texel, expanded to RGBA by the channel mode, and gives no result.
//            A sample item gives exactly one transaction on rsp_*.
//   csr_*  : register writes, taken in the cycle csr_we is high.
// Sequence:
//   Write items are taken one per cycle while no sample is in progress.
//   A sample holds the input until its result is loaded into the output
//   register. A bilinear sample passes SCALE and ADDR (scaling and
//   addressing), four texel reads from the single-port texel memory, a
//   read-latency wait, VERT and HORZ (the blend steps) and the result load.
//   A nearest sample, or one at the image edge, reads only the base texel.
// Reset:
//   Registers return to width 256, height 256, bilinear, RGBA; the texel
//   memory is not cleared and must be written before it is sampled.
// Stall:
//   The finished result sits in the output register; write items are still
//   taken, and a following sample waits in its last step until rsp_ready.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bts_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bts_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [bts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bts_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers
   logic [bts_pkg::SIZE_W-1:0] image_width_ff;
   logic [bts_pkg::SIZE_W-1:0] image_height_ff;
   logic                       filter_mode_ff;
   logic [1:0]                 channel_mode_ff;

   logic [bts_pkg::SIZE_W-1:0] img_w;
   logic [bts_pkg::SIZE_W-1:0] img_h;

   // Control
   bts_pkg::state_type state_ff, state_in;
   logic [1:0]         fetch_cnt_ff, fetch_cnt_in;
   logic               rd_valid_ff;
   logic [1:0]         rd_idx_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic               req_accept;

   // Texel memory
   logic [31:0]                 texel_mem_ff [bts_pkg::STORE_DEPTH];
   logic [31:0]                 rd_data_ff;
   logic [bts_pkg::ADDR_W-1:0]  mem_addr;
   logic [bts_pkg::ADDR_W-1:0]  fetch_addr;
   logic                        mem_we;
   logic                        mem_re;
   logic [31:0]                 wr_texel;

   // Datapath
   logic [bts_pkg::COORD_W-1:0] u_ff, v_ff;
   logic [25:0]                 tx_full, ty_full;
   logic [bts_pkg::SIZE_W-1:0]  ix0_ff, iy0_ff;
   logic [bts_pkg::FRAC_W-1:0]  wx_ff, wy_ff;
   logic [17:0]                 base_full;
   logic [bts_pkg::ADDR_W-1:0]  base_ff;
   logic                        edge_hit;
   logic                        near_ff;
   logic                        fallback_ff;
   logic [31:0]                 tex_ff [4];

   logic signed [8:0]  vdiff_l   [4];
   logic signed [8:0]  vdiff_r   [4];
   logic signed [26:0] left_calc [4];
   logic signed [26:0] right_calc[4];
   logic [23:0]        left_ff   [4];
   logic [23:0]        right_ff  [4];
   logic signed [24:0] hdiff     [4];
   logic signed [42:0] sum_calc  [4];
   logic [39:0]        sum_ff    [4];
   logic [39:0]        rnd       [4];

   bts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // -------------------------------------------------------------------------
   // Configuration
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 9'd256;
         image_height_ff <= 9'd256;
         filter_mode_ff  <= bts_pkg::FILTER_BILINEAR;
         channel_mode_ff <= bts_pkg::CHAN_RGBA;
      end else if (csr_we) begin
         case (csr_index)
            bts_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata;
            bts_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            bts_pkg::CSR_FILTER_MODE:  filter_mode_ff  <= csr_wdata[0];
            bts_pkg::CSR_CHANNEL_MODE: channel_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Zero reads as one, oversize saturates at the store limits
   always_comb begin
      if (image_width_ff == '0) begin
         img_w = 9'd1;
      end else if (32'(image_width_ff) > bts_pkg::MAX_WIDTH) begin
         img_w = bts_pkg::SIZE_W'(bts_pkg::MAX_WIDTH);
      end else begin
         img_w = image_width_ff;
      end
      if (image_height_ff == '0) begin
         img_h = 9'd1;
      end else if (32'(image_height_ff) > bts_pkg::MAX_HEIGHT) begin
         img_h = bts_pkg::SIZE_W'(bts_pkg::MAX_HEIGHT);
      end else begin
         img_h = image_height_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Texel memory: one port, writes from IDLE, reads from FETCH
   // -------------------------------------------------------------------------
   assign req_ready  = (state_ff == bts_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      case (channel_mode_ff)
         bts_pkg::CHAN_GRAY: wr_texel = {8'hFF, req_data.in_red, req_data.in_red,
                                         req_data.in_red};
         bts_pkg::CHAN_RGB:  wr_texel = {8'hFF, req_data.in_blue, req_data.in_green,
                                         req_data.in_red};
         default:            wr_texel = {req_data.in_alpha, req_data.in_blue,
                                         req_data.in_green, req_data.in_red};
      endcase
   end

   assign mem_we = req_accept && (req_data.op == bts_pkg::OP_WRITE) &&
                   (32'(req_data.texel_index) < bts_pkg::STORE_DEPTH);
   assign mem_re = (state_ff == bts_pkg::ST_FETCH);

   // Neighbor order: base, right, lower, lower-right
   assign fetch_addr = base_ff
                     + (fetch_cnt_ff[1] ? bts_pkg::ADDR_W'(img_w) : '0)
                     + bts_pkg::ADDR_W'(fetch_cnt_ff[0]);

   assign mem_addr = (state_ff == bts_pkg::ST_IDLE)
                   ? bts_pkg::ADDR_W'(req_data.texel_index) : fetch_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         texel_mem_ff[mem_addr] <= wr_texel;
      end else if (mem_re) begin
         rd_data_ff <= texel_mem_ff[mem_addr];
      end
   end

   // -------------------------------------------------------------------------
   // Sequencer
   // -------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      fetch_cnt_in = fetch_cnt_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         bts_pkg::ST_IDLE: begin
            fetch_cnt_in = '0;
            if (req_accept && req_data.op == bts_pkg::OP_SAMPLE) begin
               state_in = bts_pkg::ST_SCALE;
            end
         end
         bts_pkg::ST_SCALE: state_in = bts_pkg::ST_ADDR;
         bts_pkg::ST_ADDR:  state_in = bts_pkg::ST_FETCH;
         bts_pkg::ST_FETCH: begin
            fetch_cnt_in = fetch_cnt_ff + 2'd1;
            if (near_ff || fetch_cnt_ff == 2'd3) begin
               state_in = bts_pkg::ST_WAIT;
            end
         end
         bts_pkg::ST_WAIT:  state_in = near_ff ? bts_pkg::ST_DONE : bts_pkg::ST_VERT;
         bts_pkg::ST_VERT:  state_in = bts_pkg::ST_HORZ;
         bts_pkg::ST_HORZ:  state_in = bts_pkg::ST_DONE;
         bts_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = bts_pkg::ST_IDLE;
            end
         end
         default: state_in = bts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bts_pkg::ST_IDLE;
         fetch_cnt_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fetch_cnt_ff <= fetch_cnt_in;
         rd_valid_ff  <= mem_re;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // -------------------------------------------------------------------------
   // Coordinate scaling and addressing
   // -------------------------------------------------------------------------
   assign tx_full = u_ff * (img_w - 9'd1);
   assign ty_full = v_ff * (img_h - 9'd1);

   assign base_full = iy0_ff * img_w + 18'(ix0_ff);
   assign edge_hit  = ({1'b0, ix0_ff} + 10'd1 >= {1'b0, img_w}) ||
                      ({1'b0, iy0_ff} + 10'd1 >= {1'b0, img_h});

   always_ff @(posedge clock) begin
      if (req_accept) begin
         u_ff <= (req_data.coord_u > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE
                                                         : req_data.coord_u;
         v_ff <= (req_data.coord_v > bts_pkg::COORD_ONE) ? bts_pkg::COORD_ONE
                                                         : req_data.coord_v;
      end
      if (state_ff == bts_pkg::ST_SCALE) begin
         ix0_ff <= tx_full[24:16];
         wx_ff  <= tx_full[15:0];
         iy0_ff <= ty_full[24:16];
         wy_ff  <= ty_full[15:0];
      end
      if (state_ff == bts_pkg::ST_ADDR) begin
         base_ff     <= bts_pkg::ADDR_W'(base_full);
         near_ff     <= (filter_mode_ff == bts_pkg::FILTER_NEAREST) || edge_hit;
         fallback_ff <= (filter_mode_ff == bts_pkg::FILTER_BILINEAR) && edge_hit;
      end
      if (rd_valid_ff) begin
         tex_ff[rd_idx_ff] <= rd_data_ff;
      end
      rd_idx_ff <= fetch_cnt_ff;
   end

   // -------------------------------------------------------------------------
   // Blend lanes, one per channel: vertical lerp, then horizontal lerp
   // -------------------------------------------------------------------------
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         vdiff_l[k]    = $signed({1'b0, tex_ff[2][8*k +: 8]})
                       - $signed({1'b0, tex_ff[0][8*k +: 8]});
         vdiff_r[k]    = $signed({1'b0, tex_ff[3][8*k +: 8]})
                       - $signed({1'b0, tex_ff[1][8*k +: 8]});
         left_calc[k]  = $signed({3'b000, tex_ff[0][8*k +: 8], 16'h0000})
                       + $signed({1'b0, wy_ff}) * vdiff_l[k];
         right_calc[k] = $signed({3'b000, tex_ff[1][8*k +: 8], 16'h0000})
                       + $signed({1'b0, wy_ff}) * vdiff_r[k];
         hdiff[k]      = $signed({1'b0, right_ff[k]}) - $signed({1'b0, left_ff[k]});
         sum_calc[k]   = $signed({3'b000, left_ff[k], 16'h0000})
                       + $signed({1'b0, wx_ff}) * hdiff[k];
         rnd[k]        = sum_ff[k] + 40'h0080000000;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         if (state_ff == bts_pkg::ST_VERT) begin
            left_ff[k]  <= left_calc[k][23:0];
            right_ff[k] <= right_calc[k][23:0];
         end
         if (state_ff == bts_pkg::ST_HORZ) begin
            sum_ff[k] <= sum_calc[k][39:0];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Output register
   // -------------------------------------------------------------------------
   always_comb begin
      if (near_ff) begin
         rsp_data_in.out_red   = tex_ff[0][7:0];
         rsp_data_in.out_green = tex_ff[0][15:8];
         rsp_data_in.out_blue  = tex_ff[0][23:16];
         rsp_data_in.out_alpha = tex_ff[0][31:24];
      end else begin
         rsp_data_in.out_red   = rnd[0][39:32];
         rsp_data_in.out_green = rnd[1][39:32];
         rsp_data_in.out_blue  = rnd[2][39:32];
         rsp_data_in.out_alpha = rnd[3][39:32];
      end
      rsp_data_in.edge_fallback = fallback_ff;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Pending result is never overwritten: a stalled DONE stays in DONE
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bts_pkg::ST_DONE && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == bts_pkg::ST_DONE))
      else $error("result overwritten while output stalled");

   // A new result only comes out of the final step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == bts_pkg::ST_DONE))
      else $error("result raised outside DONE");

   // Scaled texel position stays inside the image
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bts_pkg::ST_ADDR) |-> (ix0_ff < img_w && iy0_ff < img_h))
      else $error("texel position outside image");

   // Neighbor fetches stay inside the store
   a_fetch_range: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> (32'(fetch_addr) < bts_pkg::STORE_DEPTH))
      else $error("fetch address outside texel store");
`endif

endmodule

// ===== tb/bilinear_texture_sampler_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_texture_sampler_unit_tb
// Self-checking bench for the texture sampler. Texels are loaded through
// write transactions and sampled in nearest and bilinear mode over a range of
// image sizes and channel modes. Each result is checked field by field against
// a color predictor kept in the bench. In the random traffic test the sender
// and the receiver are throttled at random, with odds set by phase mod 4.
// ---------------------------------------------------------------------------
module bilinear_texture_sampler_unit_tb;

   localparam logic [1:0] CHAN_RGBA_ALT = 2'd3;  // undefined code, behaves as RGBA
   localparam int SETTLE_CYCLES = 16;
   localparam int ITEMS_PER_PHASE = 40;

   typedef struct {
      int unsigned addr00;
      int unsigned addr10;
      int unsigned addr01;
      int unsigned addr11;
      int unsigned wx;
      int unsigned wy;
      bit          blend;
   } footprint_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   bts_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   bts_pkg::rsp_type               rsp_data;
   logic                           csr_we;
   logic [bts_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bts_pkg::CSR_DATA_W-1:0] csr_wdata;

   logic [31:0]                texel_mem [bts_pkg::STORE_DEPTH];
   bit                         texel_written [bts_pkg::STORE_DEPTH];
   logic [bts_pkg::SIZE_W-1:0] cur_width;
   logic [bts_pkg::SIZE_W-1:0] cur_height;
   logic                       cur_filter;
   logic [1:0]                 cur_channels;

   bts_pkg::rsp_type pending_colors [$];
   int               error_count;
   int               send_idle_pct;
   int               recv_stall_pct;

   bilinear_texture_sampler_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Color predictor
   // ------------------------------------------------------------------------
   function automatic int unsigned eff_size(logic [bts_pkg::SIZE_W-1:0] s,
                                            int unsigned limit);
      if (s == 0) return 1;
      if (32'(s) > limit) return limit;
      return 32'(s);
   endfunction

   function automatic int unsigned clip_coord(logic [bts_pkg::COORD_W-1:0] c);
      return (c > bts_pkg::COORD_ONE) ? 32'(bts_pkg::COORD_ONE) : 32'(c);
   endfunction

   function automatic footprint_type locate(logic [bts_pkg::COORD_W-1:0] u,
                                            logic [bts_pkg::COORD_W-1:0] v);
      footprint_type f;
      int unsigned   w;
      int unsigned   h;
      int unsigned   tx;
      int unsigned   ty;
      int unsigned   ix;
      int unsigned   iy;
      w  = eff_size(cur_width, bts_pkg::MAX_WIDTH);
      h  = eff_size(cur_height, bts_pkg::MAX_HEIGHT);
      tx = clip_coord(u) * (w - 1);
      ty = clip_coord(v) * (h - 1);
      ix = tx >> bts_pkg::FRAC_W;
      iy = ty >> bts_pkg::FRAC_W;
      f.wx = tx & 32'hFFFF;
      f.wy = ty & 32'hFFFF;
      f.addr00 = iy * w + ix;
      f.addr10 = f.addr00 + 1;
      f.addr01 = f.addr00 + w;
      f.addr11 = f.addr01 + 1;
      f.blend  = (cur_filter == bts_pkg::FILTER_BILINEAR) && (ix + 1 < w) && (iy + 1 < h);
      return f;
   endfunction

   function automatic bts_pkg::rsp_type predict_color(footprint_type f);
      bts_pkg::rsp_type result;
      logic [31:0]      c00;
      logic [31:0]      c10;
      logic [31:0]      c01;
      logic [31:0]      c11;
      logic [31:0]      color;
      longint unsigned  left;
      longint unsigned  right;
      longint unsigned  acc;
      c00   = texel_mem[f.addr00];
      color = c00;
      if (f.blend) begin
         c10 = texel_mem[f.addr10];
         c01 = texel_mem[f.addr01];
         c11 = texel_mem[f.addr11];
         for (int k = 0; k < 4; k++) begin
            left  = (65536 - f.wy) * c00[8*k +: 8] + f.wy * c01[8*k +: 8];
            right = (65536 - f.wy) * c10[8*k +: 8] + f.wy * c11[8*k +: 8];
            acc   = (65536 - f.wx) * left + f.wx * right;
            // round half up at 32 fraction bits
            color[8*k +: 8] = 8'((acc + 64'h8000_0000) >> 32);
         end
      end
      result.out_red       = color[7:0];
      result.out_green     = color[15:8];
      result.out_blue      = color[23:16];
      result.out_alpha     = color[31:24];
      result.edge_fallback = (cur_filter == bts_pkg::FILTER_BILINEAR) && !f.blend;
      return result;
   endfunction

   function automatic void store_texel(bts_pkg::req_type t);
      logic [31:0] word;
      case (cur_channels)
         bts_pkg::CHAN_GRAY: word = {8'hFF, t.in_red, t.in_red, t.in_red};
         bts_pkg::CHAN_RGB:  word = {8'hFF, t.in_blue, t.in_green, t.in_red};
         default:            word = {t.in_alpha, t.in_blue, t.in_green, t.in_red};
      endcase
      texel_mem[t.texel_index]     = word;
      texel_written[t.texel_index] = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %02h, actual %02h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_colors
      bts_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_colors.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_colors.pop_front();
            check_field("out_red", want.out_red, rsp_data.out_red);
            check_field("out_green", want.out_green, rsp_data.out_green);
            check_field("out_blue", want.out_blue, rsp_data.out_blue);
            check_field("out_alpha", want.out_alpha, rsp_data.out_alpha);
            check_field("edge_fallback", 8'(want.edge_fallback),
                        8'(rsp_data.edge_fallback));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_item(bts_pkg::req_type item);
      bts_pkg::rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.op == bts_pkg::OP_WRITE) begin
         store_texel(item);
      end else begin
         predicted      = predict_color(locate(item.coord_u, item.coord_v));
         pending_colors = {pending_colors, predicted};
      end
   endtask

   function automatic bts_pkg::req_type junk_item();
      bts_pkg::req_type item;
      item = $bits(bts_pkg::req_type)'({$urandom, $urandom, $urandom});
      return item;
   endfunction

   task automatic write_texel(int unsigned addr, logic [31:0] word);
      bts_pkg::req_type item;
      item = junk_item();
      item.op          = bts_pkg::OP_WRITE;
      item.texel_index = addr[15:0];
      {item.in_alpha, item.in_blue, item.in_green, item.in_red} = word;
      send_item(item);
   endtask

   task automatic fill_texel(int unsigned addr);
      if (!texel_written[addr]) write_texel(addr, $urandom);
   endtask

   // Load every texel the sample will touch before sending it.
   task automatic sample_at(logic [bts_pkg::COORD_W-1:0] u,
                            logic [bts_pkg::COORD_W-1:0] v);
      footprint_type    f;
      bts_pkg::req_type item;
      f = locate(u, v);
      fill_texel(f.addr00);
      if (f.blend) begin
         fill_texel(f.addr10);
         fill_texel(f.addr01);
         fill_texel(f.addr11);
      end
      item = junk_item();
      item.op      = bts_pkg::OP_SAMPLE;
      item.coord_u = u;
      item.coord_v = v;
      send_item(item);
   endtask

   // Drop valid, wait out all results, then let trailing writes retire.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(bts_pkg::csr_index_type idx,
                              logic [bts_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         bts_pkg::CSR_IMAGE_WIDTH:  cur_width    = val;
         bts_pkg::CSR_IMAGE_HEIGHT: cur_height   = val;
         bts_pkg::CSR_FILTER_MODE:  cur_filter   = val[0];
         bts_pkg::CSR_CHANNEL_MODE: cur_channels = val[1:0];
         default: ;
      endcase
   endtask

   // Unused upper data bits carry noise; the block must mask them.
   task automatic configure(logic [bts_pkg::SIZE_W-1:0] img_w,
                            logic [bts_pkg::SIZE_W-1:0] img_h,
                            logic filter, logic [1:0] channels);
      settle();
      program_reg(bts_pkg::CSR_IMAGE_WIDTH, img_w);
      program_reg(bts_pkg::CSR_IMAGE_HEIGHT, img_h);
      program_reg(bts_pkg::CSR_FILTER_MODE, {8'($urandom), filter});
      program_reg(bts_pkg::CSR_CHANNEL_MODE, {7'($urandom), channels});
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_reset_defaults();
      sample_at(17'd0, 17'd0);
      sample_at(bts_pkg::COORD_ONE, bts_pkg::COORD_ONE);
      sample_at(17'd32768, 17'd12345);
   endtask

   task automatic test_blend_corners();
      configure(9'd2, 9'd2, bts_pkg::FILTER_BILINEAR, bts_pkg::CHAN_RGBA);
      write_texel(0, 32'h0000_0000);
      write_texel(1, 32'hFFFF_FFFF);
      write_texel(2, 32'h80FF_0001);
      write_texel(3, 32'h7F00_FF02);
      sample_at(17'd0, 17'd0);
      sample_at(17'd32768, 17'd32768);          // exact halves round up
      sample_at(17'd65535, 17'd65535);
      sample_at(bts_pkg::COORD_ONE, 17'd0);     // right neighbour off the edge
      sample_at(17'd0, bts_pkg::COORD_ONE);     // lower neighbour off the edge
      sample_at(17'h1FFFF, 17'd1);              // saturates to one
      sample_at(17'd1, 17'd65535);
   endtask

   task automatic test_filter_and_channel_modes();
      configure(9'd2, 9'd2, bts_pkg::FILTER_NEAREST, bts_pkg::CHAN_GRAY);
      write_texel(0, $urandom);
      sample_at(17'd32767, 17'd32768);
      sample_at(bts_pkg::COORD_ONE, bts_pkg::COORD_ONE);
      configure(9'd2, 9'd2, bts_pkg::FILTER_BILINEAR, bts_pkg::CHAN_RGB);
      write_texel(1, $urandom);
      sample_at(17'd40000, 17'd20000);
      configure(9'd2, 9'd2, bts_pkg::FILTER_BILINEAR, CHAN_RGBA_ALT);
      write_texel(2, $urandom);
      sample_at(17'd20000, 17'd50000);
   endtask

   task automatic test_size_limits();
      configure(9'd0, 9'd511, bts_pkg::FILTER_BILINEAR, bts_pkg::CHAN_RGBA);
      sample_at(17'd50000, 17'd50000);
      configure(9'd511, 9'd0, bts_pkg::FILTER_BILINEAR, bts_pkg::CHAN_RGBA);
      sample_at(17'd50000, 17'd50000);
      configure(9'd257, 9'd256, bts_pkg::FILTER_BILINEAR, bts_pkg::CHAN_RGBA);
      sample_at(bts_pkg::COORD_ONE, 17'd65000);
   endtask

   function automatic logic [bts_pkg::SIZE_W-1:0] random_size();
      case ($urandom_range(9))
         0:       return 9'd256;
         1:       return 9'd1;
         2:       return 9'd0;
         3:       return 9'($urandom_range(257, 511));
         default: return 9'($urandom_range(2, 16));
      endcase
   endfunction

   function automatic logic [bts_pkg::COORD_W-1:0] random_coord();
      case ($urandom_range(9))
         0:       return '0;
         1:       return bts_pkg::COORD_ONE;
         2:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(65535));
      endcase
   endfunction

   task automatic random_item();
      int unsigned area;
      area = eff_size(cur_width, bts_pkg::MAX_WIDTH)
           * eff_size(cur_height, bts_pkg::MAX_HEIGHT);
      case ($urandom_range(9))
         0:       write_texel($urandom_range(area - 1), $urandom);
         1:       write_texel($urandom_range(bts_pkg::STORE_DEPTH - 1), $urandom);
         default: sample_at(random_coord(), random_coord());
      endcase
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       configure(9'd256, 9'd256, bts_pkg::FILTER_BILINEAR,
                               bts_pkg::CHAN_RGBA);
            1:       configure(9'd1, 9'd1, bts_pkg::FILTER_NEAREST, bts_pkg::CHAN_GRAY);
            2:       configure(9'd16, 9'd2, bts_pkg::FILTER_BILINEAR, bts_pkg::CHAN_RGB);
            default: configure(random_size(), random_size(), 1'($urandom),
                               2'($urandom_range(3)));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         repeat (ITEMS_PER_PHASE) random_item();
      end
   endtask

   initial begin
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = bts_pkg::CSR_IMAGE_WIDTH;
      csr_wdata      = '0;
      cur_width      = 9'd256;
      cur_height     = 9'd256;
      cur_filter     = bts_pkg::FILTER_BILINEAR;
      cur_channels   = bts_pkg::CHAN_RGBA;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_blend_corners();
      test_filter_and_channel_modes();
      test_size_limits();
      test_random_traffic();
      settle();

      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/bts_pkg.sv
rtl/bilinear_texture_sampler_unit.sv
tb/bilinear_texture_sampler_unit_tb.sv
